[rtl/sdhl_pkg.sv]
// Shared types and constants for the shot detect heat limiter.
package sdhl_pkg;

  localparam logic CMD_FRICTION = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  localparam logic [1:0] CFG_HEAT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_COOL_RATE  = 2'd1;
  localparam logic [1:0] CFG_MIN_GAP    = 2'd2;

  localparam logic [16:0] ERR_LOW   = 17'd200;
  localparam logic [16:0] ERR_HIGH  = 17'd1000;
  localparam logic [16:0] SPEED_MIN = 17'd3000;

  localparam logic signed [15:0] GAP_MAX    = 16'sd32767;
  localparam logic signed [15:0] MODE_GUARD = -16'sd200;

  localparam logic [7:0]  PENDING_MAX  = 8'hFF;
  localparam logic [13:0] BULLET_MILLI = 14'd10000;
  localparam logic [9:0]  REF_SCALE    = 10'd1000;
  localparam logic [9:0]  THR_SCALE    = 10'd950;
  localparam logic [16:0] BULLET_HEAT  = 17'd10;

  localparam logic [15:0] HEAT_LIMIT_RESET = 16'd100;
  localparam logic [15:0] COOL_RESET       = 16'd10;
  localparam logic [14:0] MIN_GAP_RESET    = 15'd100;
  localparam logic [25:0] THR_RESET        = 26'd85500;

  typedef struct packed {
    logic              command;
    logic [9:0]        elapsed_ms;
    logic signed [15:0] speed_error;
    logic signed [15:0] wheel_speed;
    logic [2:0]        shoot_mode;
    logic              referee_fresh;
    logic [15:0]       referee_heat;
  } sdhl_item_t;

  typedef struct packed {
    logic        fire_allowed;
    logic [31:0] heat_milli;
    logic [31:0] shot_total;
  } sdhl_result_t;

  // pre-decoded request handed from the input stage to the update stage
  typedef struct packed {
    logic        command;
    logic [9:0]  elapsed_ms;
    logic [2:0]  shoot_mode;
    logic        shot_cond;
    logic        referee_fresh;
    logic [25:0] referee_milli;
    logic [25:0] cool_milli;
  } sdhl_prep_t;

endpackage

[rtl/sdhl_in_stage.sv]
// Input register: captures a request with its products and speed window check.
module sdhl_in_stage
  import sdhl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  sdhl_item_t  item,
  input  logic [15:0] cool_per_second,
  output logic        prep_valid,
  input  logic        prep_ready,
  output sdhl_prep_t  prep
);

  logic [16:0] err_abs;
  logic [16:0] spd_abs;
  logic [25:0] ref_prod;
  logic [25:0] cool_prod;
  sdhl_prep_t  prep_next;

  assign item_ready = !rst && (!prep_valid || prep_ready);

  assign err_abs = item.speed_error[15] ? (17'd0 - {1'b1, item.speed_error})
                                        : {1'b0, item.speed_error};
  assign spd_abs = item.wheel_speed[15] ? (17'd0 - {1'b1, item.wheel_speed})
                                        : {1'b0, item.wheel_speed};
  assign ref_prod  = item.referee_heat * REF_SCALE;
  assign cool_prod = cool_per_second * item.elapsed_ms;

  always_comb begin
    prep_next.command       = item.command;
    prep_next.elapsed_ms    = item.elapsed_ms;
    prep_next.shoot_mode    = item.shoot_mode;
    prep_next.shot_cond     = (err_abs > ERR_LOW) && (err_abs < ERR_HIGH)
                              && (spd_abs > SPEED_MIN);
    prep_next.referee_fresh = item.referee_fresh;
    prep_next.referee_milli = ref_prod;
    prep_next.cool_milli    = cool_prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (item_ready) begin
      prep_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      prep <= prep_next;
    end
  end

endmodule

[rtl/sdhl_core.sv]
// State update for shot counting and heat estimate, with the result register.
module sdhl_core
  import sdhl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         prep_valid,
  output logic         prep_ready,
  input  sdhl_prep_t   prep,
  input  logic [14:0]  min_shot_gap_ms,
  input  logic         thr_pos,
  input  logic [25:0]  thr_mag,
  output logic         result_valid,
  input  logic         result_ready,
  output sdhl_result_t result
);

  logic [2:0]         last_mode;
  logic signed [15:0] gap_counter_ms;
  logic [7:0]         pending_shots;
  logic [31:0]        total_shots;
  logic [31:0]        heat_estimate;
  logic               allowed_flag;

  logic [2:0]         last_mode_next;
  logic signed [15:0] gap_counter_ms_next;
  logic [7:0]         pending_shots_next;
  logic [31:0]        total_shots_next;
  logic [31:0]        heat_estimate_next;
  logic               allowed_flag_next;

  logic               adv;
  logic signed [16:0] gap_sum;
  logic signed [15:0] gap_sat;
  logic signed [15:0] gap_mode;
  logic               shot;
  logic [21:0]        pend_milli;
  logic signed [34:0] heat_sum;
  logic [31:0]        heat_clamp;

  assign prep_ready = !result_valid || result_ready;
  assign adv        = prep_valid && prep_ready;

  assign gap_sum  = {gap_counter_ms[15], gap_counter_ms} + $signed({7'd0, prep.elapsed_ms});
  assign gap_sat  = (gap_sum > 17'sd32767) ? GAP_MAX : gap_sum[15:0];
  assign gap_mode = (prep.shoot_mode != last_mode) ? MODE_GUARD : gap_sat;
  assign shot     = prep.shot_cond && (gap_mode > $signed({1'b0, min_shot_gap_ms}));

  assign pend_milli = pending_shots * BULLET_MILLI;
  assign heat_sum   = $signed({3'd0, heat_estimate}) + $signed({13'd0, pend_milli})
                      - $signed({9'd0, prep.cool_milli});

  always_comb begin
    if (heat_sum[34]) begin
      heat_clamp = 32'd0;
    end else if (heat_sum[33:32] != 2'd0) begin
      heat_clamp = 32'hFFFF_FFFF;
    end else begin
      heat_clamp = heat_sum[31:0];
    end
  end

  always_comb begin
    last_mode_next      = last_mode;
    gap_counter_ms_next = gap_counter_ms;
    pending_shots_next  = pending_shots;
    total_shots_next    = total_shots;
    heat_estimate_next  = heat_estimate;
    allowed_flag_next   = allowed_flag;
    if (prep.command == CMD_FRICTION) begin
      last_mode_next      = prep.shoot_mode;
      gap_counter_ms_next = gap_mode;
      if (shot) begin
        gap_counter_ms_next = 16'sd0;
        total_shots_next    = total_shots + 32'd1;
        if (pending_shots != PENDING_MAX) begin
          pending_shots_next = pending_shots + 8'd1;
        end
      end
    end else begin
      if (prep.referee_fresh) begin
        heat_estimate_next = {6'd0, prep.referee_milli};
      end else begin
        heat_estimate_next = heat_clamp;
        pending_shots_next = 8'd0;
      end
      allowed_flag_next = thr_pos && (heat_estimate_next < {6'd0, thr_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode      <= 3'd0;
      gap_counter_ms <= 16'sd0;
      pending_shots  <= 8'd0;
      total_shots    <= 32'd0;
      heat_estimate  <= 32'd0;
      allowed_flag   <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (prep_ready) begin
        result_valid <= prep_valid;
      end
      if (adv) begin
        last_mode      <= last_mode_next;
        gap_counter_ms <= gap_counter_ms_next;
        pending_shots  <= pending_shots_next;
        total_shots    <= total_shots_next;
        heat_estimate  <= heat_estimate_next;
        allowed_flag   <= allowed_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.fire_allowed <= allowed_flag_next;
      result.heat_milli   <= heat_estimate_next;
      result.shot_total   <= total_shots_next;
    end
  end

`ifndef SYNTH
  a_pending_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && prep.command == CMD_TICK && !prep.referee_fresh |=> pending_shots == 8'd0)
    else $error("pending shots not cleared by heat tick");

  a_gap_floor: assert property (@(posedge clk) disable iff (rst)
    gap_counter_ms >= MODE_GUARD)
    else $error("gap counter below mode guard");

  a_total_only_friction: assert property (@(posedge clk) disable iff (rst)
    !(adv && prep.command == CMD_FRICTION) |=> $stable(total_shots))
    else $error("shot total moved without friction sample");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv |=> result_valid && result.shot_total == total_shots)
    else $error("result register out of step with state");
`endif

endmodule

[rtl/shot_detect_heat_limiter.sv]
// Shot detect and heat limiter top level: config registers and stage wiring.
// Pipeline: two register stages, the input register and the result register; a
// result becomes valid once its request has passed through both of them.
// Throughput: one request per cycle while results are taken; a stalled result
// fills the input register and then holds item_ready low until it is taken.
// Reset (rst, synchronous): counters, heat estimate and flags clear to zero,
// config registers return to heat limit 100, cooling 10/s, shot gap 100 ms.
module shot_detect_heat_limiter
  import sdhl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  sdhl_item_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output sdhl_result_t result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] cool_per_second;
  logic [14:0] min_shot_gap_ms;
  logic        thr_pos;
  logic [25:0] thr_mag;

  logic [16:0] limit_less;
  logic [25:0] thr_prod;

  logic        prep_valid;
  logic        prep_ready;
  sdhl_prep_t  prep;

  assign cfg_ready = !rst;

  // firing threshold 950 * (limit - 10), kept as sign and magnitude
  assign limit_less = {1'b0, cfg_data} - BULLET_HEAT;
  assign thr_prod   = limit_less[15:0] * THR_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      cool_per_second <= COOL_RESET;
      min_shot_gap_ms <= MIN_GAP_RESET;
      thr_pos         <= HEAT_LIMIT_RESET > BULLET_HEAT[15:0];
      thr_mag         <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAT_LIMIT: begin
          thr_pos <= !limit_less[16] && (limit_less != 17'd0);
          thr_mag <= thr_prod;
        end
        CFG_COOL_RATE: begin
          cool_per_second <= cfg_data;
        end
        CFG_MIN_GAP: begin
          min_shot_gap_ms <= cfg_data[14:0];
        end
        default: begin
        end
      endcase
    end
  end

  sdhl_in_stage u_in_stage (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .cool_per_second (cool_per_second),
    .prep_valid      (prep_valid),
    .prep_ready      (prep_ready),
    .prep            (prep)
  );

  sdhl_core u_core (
    .clk             (clk),
    .rst             (rst),
    .prep_valid      (prep_valid),
    .prep_ready      (prep_ready),
    .prep            (prep),
    .min_shot_gap_ms (min_shot_gap_ms),
    .thr_pos         (thr_pos),
    .thr_mag         (thr_mag),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result)
  );

endmodule
